// ===== rtl/core/svpwm_pkg.sv =====
// Shared types, register map and reset values for the servo valve PWM block.
`timescale 1ns / 1ps
package svpwm_pkg;

	localparam int unsigned OVERFLOW_TICKS = 65536;
	localparam logic [15:0] PRESCALE_LAST  = 16'(OVERFLOW_TICKS - 1);

	localparam logic [15:0] PERIOD_RESET  = 16'd20000;
	localparam logic [15:0] OPEN_RESET    = 16'd500;
	localparam logic [15:0] CLOSED_RESET  = 16'd1150;
	localparam logic [15:0] TIMEOUT_RESET = 16'd150;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_PERIOD  = 2'd0,
		REG_OPEN    = 2'd1,
		REG_CLOSED  = 2'd2,
		REG_TIMEOUT = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [15:0] period_ticks;
		logic [15:0] open_pulse_ticks;
		logic [15:0] closed_pulse_ticks;
		logic [15:0] open_timeout_overflows;
	} cfg_t;

	typedef struct packed {
		logic servo_pin;
		logic valve_open;
	} result_t;

endpackage

// ===== rtl/core/svpwm_core.sv =====
// Valve state, overflow prescaler and PWM phase, advanced once per tick.
`timescale 1ns / 1ps
module svpwm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             command_level,
	input  svpwm_pkg::cfg_t  cfg,
	output svpwm_pkg::result_t result
);
	import svpwm_pkg::*;

	logic [15:0] phase_q;
	logic [15:0] width_q;
	logic        drive_q;
	logic        open_q;
	logic        armed_q;
	logic        prev_q;
	logic [15:0] prescale_q;
	logic [15:0] elapsed_q;

	logic        rise, fall;
	logic        open1, armed1, open2, armed2;
	logic [15:0] elapsed1, elapsed2;
	logic        wrap;
	logic [15:0] period;
	logic [16:0] phase_inc;
	logic        last_phase;
	logic        pulse_end;
	logic        drive_d;
	logic        timed_out;
	logic [15:0] width_d;
	logic [15:0] phase_d;
	logic [15:0] prescale_d;

	always_comb begin
		rise = command_level && !prev_q;
		fall = !command_level && prev_q;
		open1    = rise ? 1'b1 : (fall ? 1'b0 : open_q);
		armed1   = rise ? 1'b1 : (fall ? 1'b0 : armed_q);
		elapsed1 = rise ? 16'd0 : elapsed_q;

		wrap       = (prescale_q == PRESCALE_LAST);
		prescale_d = wrap ? 16'd0 : prescale_q + 16'd1;
		elapsed2   = (wrap && elapsed1 != 16'hFFFF) ? elapsed1 + 16'd1 : elapsed1;

		period     = (cfg.period_ticks == 16'd0) ? 16'd1 : cfg.period_ticks;
		phase_inc  = {1'b0, phase_q} + 17'd1;
		last_phase = (phase_inc >= {1'b0, period});

		drive_d = (phase_q == 16'd0) ? 1'b1 : drive_q;
		if (width_q < period) begin
			pulse_end = (phase_q == width_q);
			if (pulse_end) begin
				drive_d = 1'b0;
			end
		end else begin
			pulse_end = last_phase;
		end

		timed_out = pulse_end && armed1 && (elapsed2 >= cfg.open_timeout_overflows);
		open2  = timed_out ? 1'b0 : open1;
		armed2 = timed_out ? 1'b0 : armed1;

		width_d = width_q;
		if (pulse_end) begin
			width_d = open2 ? cfg.open_pulse_ticks : cfg.closed_pulse_ticks;
		end

		phase_d = last_phase ? 16'd0 : phase_inc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			width_q    <= CLOSED_RESET;
			drive_q    <= 1'b0;
			open_q     <= 1'b0;
			armed_q    <= 1'b0;
			prev_q     <= 1'b0;
			prescale_q <= '0;
			elapsed_q  <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			width_q    <= width_d;
			drive_q    <= drive_d;
			open_q     <= open2;
			armed_q    <= armed2;
			prev_q     <= command_level;
			prescale_q <= prescale_d;
			elapsed_q  <= elapsed2;
		end
	end

	assign result.servo_pin  = drive_d;
	assign result.valve_open = open2;

endmodule

// ===== rtl/core/servo_valve_pwm_with_timeout.sv =====
// Top level of the servo valve PWM generator with timed auto-close.
//
// Each input request is one timer tick carrying the sampled command pin
// level (command_level); each tick yields exactly one result request with
// the servo drive level (servo_pin) and the valve state (valve_open).
// Both channels use valid/stall; a request moves at an edge with valid
// high and stall low.
// A tick is captured in an input register; when the output side is free
// its state update runs and the result lands in the output register,
// raising out_valid. One tick is taken every cycle as long as the output
// side keeps up; the rate is set by the single input-to-output register
// pair. When out_stall is high with a result waiting, the result holds
// and the waiting input stage holds; in_stall rises only when both are
// full. Reset clears the pipeline and the PWM state (phase 0, closed
// width, pin low, valve closed) and loads the register defaults.
// Registers are written over the APB port, at byte address 4*index;
// the user must write them only while idle; the block does not check it.
`timescale 1ns / 1ps
module servo_valve_pwm_with_timeout (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command_level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        servo_pin,
	output logic                        valve_open,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svpwm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import svpwm_pkg::*;

	cfg_t       cfg_q;
	reg_index_t reg_idx;
	logic       valid_s1;
	logic       cmd_s1;
	logic       out_free;
	logic       move_s1;
	logic       load_s1;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks           <= PERIOD_RESET;
			cfg_q.open_pulse_ticks       <= OPEN_RESET;
			cfg_q.closed_pulse_ticks     <= CLOSED_RESET;
			cfg_q.open_timeout_overflows <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_PERIOD:  cfg_q.period_ticks           <= pwdata[15:0];
				REG_OPEN:    cfg_q.open_pulse_ticks       <= pwdata[15:0];
				REG_CLOSED:  cfg_q.closed_pulse_ticks     <= pwdata[15:0];
				REG_TIMEOUT: cfg_q.open_timeout_overflows <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PERIOD:  prdata = {16'd0, cfg_q.period_ticks};
			REG_OPEN:    prdata = {16'd0, cfg_q.open_pulse_ticks};
			REG_CLOSED:  prdata = {16'd0, cfg_q.closed_pulse_ticks};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.open_timeout_overflows};
			default:     prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && out_free;
	assign load_s1  = !valid_s1 || move_s1;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cmd_s1 <= command_level;
		end
	end

	svpwm_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (move_s1),
		.command_level (cmd_s1),
		.cfg           (cfg_q),
		.result        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign servo_pin  = res_q.servo_pin;
	assign valve_open = res_q.valve_open;

endmodule

// ===== rtl/core/svpwm_checker.sv =====
// Port-level checker for the servo valve PWM block, bound to the top level.
`timescale 1ns / 1ps
module svpwm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        servo_pin,
	input logic                        valve_open,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [svpwm_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);
	import svpwm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(servo_pin) && $stable(valve_open))
		else $error("stalled result changed");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output empty");

	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
		##1 psel && !pwrite && paddr[3:2] == $past(paddr[3:2])
		|-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("register readback mismatch");

endmodule

bind servo_valve_pwm_with_timeout svpwm_checker u_svpwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.servo_pin  (servo_pin),
	.valve_open (valve_open),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata),
	.pready     (pready)
);
